[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the compander RTL
// Clocked on clk, switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define MLC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define MLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mlc_pkg.sv]
// ----------------------------------------------------------------------------
// mlc_pkg
// Constants, segment tables and fixed-point widths for the mu-law compander.
// ----------------------------------------------------------------------------
package mlc_pkg;

  // Default sample width (signed Q1.15)
  localparam int SAMPLE_BITS_DEF = 16;

  // Mode codes
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // Decode runs in Q.24 whatever the sample width
  localparam int EXP_FRAC = 24;

  // Segment slope/offset, scaled by 2500
  localparam int SLOPE_W = 12;

  // Numerator of the exp segment: slope * Q.24 + offset * 2^24
  localparam int N_W    = SLOPE_W + EXP_FRAC + 1;
  localparam int N_LO_W = 19;
  localparam int N_HI_W = N_W - N_LO_W;

  // Divide by 2500: reciprocal multiply with one correction step
  localparam int               RECIP2500_SHIFT = N_W;
  localparam int               RECIP2500_W     = 26;
  localparam logic [25:0]      RECIP2500       = 26'd54975581;
  localparam int               REM2500_W       = 13;
  localparam logic [12:0]      DIV2500         = 13'd2500;
  localparam int               SUM2500_W       = N_W + RECIP2500_W;

  // Widths of the exp value and its powers (value bounded by 2^(EXP_FRAC+n))
  localparam int P1_W = EXP_FRAC + 2;
  localparam int P2_W = EXP_FRAC + 3;
  localparam int P4_W = EXP_FRAC + 5;
  localparam int P8_W = EXP_FRAC + 9;
  localparam logic [P1_W-1:0] P1_MAX = P1_W'(1) << (EXP_FRAC + 1);
  localparam logic [P8_W-1:0] P8_ONE = P8_W'(1) << EXP_FRAC;

  // Divide by 255: reciprocal multiply with one correction step
  localparam int          RECIP255_SHIFT = 32;
  localparam int          RECIP255_W     = 25;
  localparam logic [24:0] RECIP255       = 25'd16843009;
  localparam int          REM255_W       = 9;
  localparam logic [8:0]  DIV255         = 9'd255;

  // Width of the encode octave index
  localparam int OCT_W = 4;

  function automatic logic [SLOPE_W-1:0] seg_slope(input logic [1:0] seg);
    logic [SLOPE_W-1:0] s;
    case (seg)
      2'd0:    s = 12'd1892;
      2'd1:    s = 12'd2250;
      2'd2:    s = 12'd2680;
      default: s = 12'd3182;
    endcase
    return s;
  endfunction

  function automatic logic [SLOPE_W-1:0] seg_offset(input logic [1:0] seg);
    logic [SLOPE_W-1:0] o;
    case (seg)
      2'd0:    o = 12'd2500;
      2'd1:    o = 12'd2410;
      2'd2:    o = 12'd2195;
      default: o = 12'd1818;
    endcase
    return o;
  endfunction

endpackage

[rtl/mlc_if.sv]
// ----------------------------------------------------------------------------
// mlc_if
// Valid/ready channels for compander samples and results.
// ----------------------------------------------------------------------------
interface mlc_sample_if import mlc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic signed [SAMPLE_BITS-1:0] sample_value;

  modport source (output valid, mode, sample_value, input ready);
  modport sink   (input valid, mode, sample_value, output ready);
endinterface

interface mlc_result_if import mlc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-2:0] result_magnitude;
  logic                   saturated;

  modport source (output valid, result_magnitude, saturated, input ready);
  modport sink   (input valid, result_magnitude, saturated, output ready);
endinterface

[rtl/mu_law_compander_piecewise.sv]
// ----------------------------------------------------------------------------
// mu_law_compander_piecewise
// Stateless piecewise-linear mu-law (mu = 255) compander, encode or decode.
// ----------------------------------------------------------------------------
// Takes one signed sample per cycle while sample.ready is high and returns
// one unsigned magnitude per item. The depth is set by the decode path: a
// reciprocal divide by 2500 split over three stages, three squaring
// multipliers of one stage each, and a reciprocal divide by 255 over two
// stages, followed by the output register. Encode items travel through the
// same stages so that results leave in order. Each stage holds its own valid
// bit and loads when it is empty or the next one moves, so back pressure on
// the result side does not stop intake until the pipeline is full. Results of
// 1.0 or more are clamped to all ones with saturated set.
// The interface instances must carry the same SAMPLE_BITS as this module.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mu_law_compander_piecewise import mlc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  mlc_sample_if.sink   sample,
  mlc_result_if.source result
);

  localparam int F     = SAMPLE_BITS - 1;
  localparam int SH    = EXP_FRAC - F;
  localparam int VW    = F + 9;
  localparam int TW    = F + 8;
  localparam int PRW   = TW + RECIP255_W;
  localparam int NSTG  = 11;
  localparam int LAST  = NSTG - 1;

  // Per-stage valid and advance
  logic [NSTG-1:0] vld;
  logic [NSTG:0]   adv;

  // Stage 0: magnitude
  logic [F:0]              a0;
  // Stage 1: encode argument, decode numerator
  logic [VW-1:0]           v1;
  logic [N_W-1:0]          n1;
  // Stage 2: encode result, partial products of the divide by 2500
  logic [N_LO_W+RECIP2500_W-1:0] pl2;
  logic [N_HI_W+RECIP2500_W-1:0] ph2;
  logic [REM2500_W-1:0]    nl2;
  // Stage 3: estimated quotient
  logic [P1_W-1:0]         q3;
  logic [REM2500_W-1:0]    nl3;
  // Stages 4 to 7: exp value and its powers
  logic [P1_W-1:0]         p1;
  logic [P2_W-1:0]         p2;
  logic [P4_W-1:0]         p4;
  logic [P8_W-1:0]         p8;
  // Stage 8: product for the divide by 255
  logic [PRW-1:0]          pr8;
  logic [REM255_W-1:0]     tl8;
  // Stage 9: magnitude before the clamp
  logic [F:0]              mag9;
  // Mode and encode result carried alongside
  logic                    mode [0:8];
  logic [F:0]              enc  [2:8];

  // Next values
  logic [F:0]              a0_next;
  logic [EXP_FRAC:0]       y24;
  logic [1:0]              seg;
  logic [N_W-1:0]          smul;
  logic [VW-1:0]           v1_next;
  logic [N_W-1:0]          n1_next;
  logic [OCT_W-1:0]        oct;
  logic [VW-1:0]           vrem;
  logic [VW-1:0]           vshf;
  logic [F:0]              enc_next;
  logic [SUM2500_W-1:0]    sum3;
  logic [REM2500_W-1:0]    qm4;
  logic [REM2500_W-1:0]    r4;
  logic [P1_W-1:0]         p1_next;
  logic [2*P1_W-1:0]       sq5;
  logic [2*P2_W-1:0]       sq6;
  logic [2*P4_W-1:0]       sq7;
  logic [P8_W-1:0]         d8;
  logic [TW-1:0]           t8;
  logic [F:0]              q9;
  logic [REM255_W-1:0]     qm9;
  logic [REM255_W-1:0]     r9;
  logic [F:0]              qd9;
  logic [F:0]              mag9_next;

  // Advance a stage when it is empty or the one after it moves
  always_comb begin
    adv[NSTG] = result.ready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign sample.ready = adv[0];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= sample.valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 0: drop the sign (most negative gives exactly 1.0)
  always_comb begin
    if (sample.sample_value[F]) begin
      a0_next = ~$unsigned(sample.sample_value) + (F+1)'(1);
    end else begin
      a0_next = $unsigned(sample.sample_value);
    end
  end

  // Stage 1: 1 + 255|x| for encode, segment numerator for decode
  always_comb begin
    y24     = {a0, {SH{1'b0}}};
    seg     = y24[EXP_FRAC] ? 2'd3 : y24[EXP_FRAC-1:EXP_FRAC-2];
    smul    = seg_slope(seg) * y24;
    n1_next = smul + N_W'({seg_offset(seg), {EXP_FRAC{1'b0}}});
    v1_next = (VW'(1) << F) + {a0, 8'b0} - VW'(a0);
  end

  // Stage 2: octave search and linear fraction; split reciprocal product
  always_comb begin
    oct = '0;
    for (int j = 1; j <= 8; j++) begin
      if (v1[F+j]) begin
        oct = OCT_W'(j);
      end
    end
    vrem     = v1 & ~(VW'(1) << (F + int'(oct)));
    vshf     = vrem >> (oct + OCT_W'(3));
    enc_next = {oct, vshf[F-4:0]};
  end

  // Stage 3: recombine partial products into the quotient estimate
  always_comb begin
    sum3 = {ph2, {N_LO_W{1'b0}}} + SUM2500_W'(pl2);
  end

  // Stage 4: correct the estimate by one when the remainder allows
  always_comb begin
    qm4     = REM2500_W'(q3[REM2500_W-1:0] * DIV2500);
    r4      = nl3 - qm4;
    p1_next = q3 + P1_W'(r4 >= DIV2500);
  end

  // Stages 5 to 7: square three times, truncated to Q.24
  always_comb begin
    sq5 = p1 * p1;
    sq6 = p2 * p2;
    sq7 = p4 * p4;
  end

  // Stage 8: subtract 1, rescale and multiply by the reciprocal of 255
  always_comb begin
    d8 = p8 - P8_ONE;
    t8 = (p8 > P8_ONE) ? d8[P8_W-2:SH] : '0;
  end

  // Stage 9: correct the quotient and pick the result for the mode
  always_comb begin
    q9  = pr8[PRW-1:RECIP255_SHIFT];
    qm9 = REM255_W'(q9[REM255_W-1:0] * DIV255);
    r9  = tl8 - qm9;
    qd9 = q9 + (F+1)'(r9 >= DIV255);
    mag9_next = (mode[8] == MODE_DECODE) ? qd9 : enc[8];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      a0      <= a0_next;
      mode[0] <= sample.mode;
    end
    if (adv[1]) begin
      v1 <= v1_next;
      n1 <= n1_next;
    end
    if (adv[2]) begin
      enc[2] <= enc_next;
      pl2    <= n1[N_LO_W-1:0] * RECIP2500;
      ph2    <= n1[N_W-1:N_LO_W] * RECIP2500;
      nl2    <= n1[REM2500_W-1:0];
    end
    if (adv[3]) begin
      q3  <= sum3[SUM2500_W-1:RECIP2500_SHIFT];
      nl3 <= nl2;
    end
    if (adv[4]) begin
      p1 <= p1_next;
    end
    if (adv[5]) begin
      p2 <= sq5[EXP_FRAC+P2_W-1:EXP_FRAC];
    end
    if (adv[6]) begin
      p4 <= sq6[EXP_FRAC+P4_W-1:EXP_FRAC];
    end
    if (adv[7]) begin
      p8 <= sq7[EXP_FRAC+P8_W-1:EXP_FRAC];
    end
    if (adv[8]) begin
      pr8 <= t8 * RECIP255;
      tl8 <= t8[REM255_W-1:0];
    end
    if (adv[9]) begin
      mag9 <= mag9_next;
    end
    for (int i = 1; i <= 8; i++) begin
      if (adv[i]) begin
        mode[i] <= mode[i-1];
      end
    end
    for (int i = 3; i <= 8; i++) begin
      if (adv[i]) begin
        enc[i] <= enc[i-1];
      end
    end
    // Output register: clamp 1.0 to all ones
    if (adv[LAST]) begin
      result.saturated        <= mag9[F];
      result.result_magnitude <= mag9[F] ? '1 : mag9[F-1:0];
    end
  end

  assign result.valid = vld[LAST];

  // Checks
  `MLC_ASSERT_IMPLY(a_ready_when_out_free, !vld[LAST], sample.ready,
                    "input stalled with free output")
  `MLC_ASSERT_NEXT(a_accept_fills, sample.valid && sample.ready, vld[0], "accepted item lost")
  `MLC_ASSERT_IMPLY(a_exp_bound, vld[4], p1 <= P1_MAX, "exp segment value above 2.0")
  `MLC_ASSERT_IMPLY(a_mag_bound, vld[9], mag9 <= ((F+1)'(1) << F), "magnitude above 1.0")
  `MLC_ASSERT_IMPLY(a_sat_ones, result.valid && result.saturated, &result.result_magnitude,
                    "saturated result not clamped")

endmodule
